// ----- design/cse_pkg.sv -----
// ============================================================================
// cse_pkg: shared widths, types and helpers for the cosine similarity engine.
// ============================================================================
`default_nettype none
package cse_pkg;

  localparam int unsigned MaxLen    = 1024;
  localparam int unsigned ElemWidth = 16;
  localparam int unsigned CountW    = 11;
  localparam int unsigned DotW      = 42;
  localparam int unsigned SqW       = 41;
  localparam int unsigned MagW      = 41;   // magnitude of the dot sum
  localparam int unsigned TgtW      = 112;  // dot^2 * 2^30
  localparam int unsigned NormW     = 82;   // a_sq * b_sq
  localparam int unsigned TestW     = 114;  // norms * m^2 (m <= 32768)
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;

  // One finished vector pair, passed from front to back.
  typedef struct packed {
    logic signed [DotW-1:0] dot;
    logic [SqW-1:0]         asq;
    logic [SqW-1:0]         bsq;
    logic                   too_long;
    logic [CountW-1:0]      count;
  } job_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
    logic               too_long;
    logic [CountW-1:0]  pair_count;
  } result_t;

endpackage
`default_nettype wire

// ----- design/cosine_similarity_engine.sv -----
// Back end: a last beat's job is loaded, then eight partial products run on one 32x32 unit,
// then a 16-pass bit search of five steps each; a zero norm skips the search, and an answer
// of exactly plus or minus one ends it after its first pass.
// Throughput: one element pair a cycle while the four-job queue has room, and a full queue
// stalls every input beat; the back end takes a new job only once its last result is taken.
// Reset: rst clears the sums, the queue and the back-end sequencer.
// ============================================================================
// cosine_similarity_engine: streaming cosine similarity of two Q1.15 vectors.
// ============================================================================
`default_nettype none
module cosine_similarity_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // a_element[15:0], b_element[31:16]
  input  wire         s_tlast,   // last_element
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // similarity[15:0], pair_count[26:16], zero fill
  output logic [1:0]  m_tuser    // zero_norm[0], too_long[1]
);
  import cse_pkg::*;

  job_t    fj, qj;
  result_t r;
  logic    fv, fr, qv, qr;

  cse_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .a_element(s_tdata[15:0]), .b_element(s_tdata[31:16]),
    .last_element(s_tlast), .job_valid(fv), .job_ready(fr), .job(fj)
  );

  cse_queue u_queue (
    .clk, .rst, .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_job(qj)
  );

  cse_back u_back (
    .clk, .rst, .job_valid(qv), .job_ready(qr), .job(qj),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(r)
  );

  assign m_tdata = {5'd0, r.pair_count, r.similarity};
  assign m_tuser = {r.too_long, r.zero_norm};
endmodule
`default_nettype wire

// ----- design/cse_front.sv -----
// ============================================================================
// cse_front: accumulator front end
// Takes one element pair a beat, keeps the three running sums and the pair
// count, and hands a finished job to the queue on the last beat.
// ============================================================================
`default_nettype none
module cse_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [15:0]           a_element,
  input  wire  [15:0]           b_element,
  input  wire                   last_element,
  output logic                  job_valid,
  input  wire                   job_ready,
  output cse_pkg::job_t         job
);
  import cse_pkg::*;

  logic signed [DotW-1:0] dot_sum;
  logic [SqW-1:0]         a_square_sum;
  logic [SqW-1:0]         b_square_sum;
  logic [CountW-1:0]      element_count;
  logic                   overflow_seen;

  logic signed [ElemWidth-1:0] a_s, b_s;
  logic signed [31:0] ab, aa, bb;
  logic               room, fire;
  logic signed [DotW-1:0] dot_next;
  logic [SqW-1:0]     asq_next, bsq_next;
  logic [CountW-1:0]  cnt_next;
  logic               ovf_next;

  // Every beat waits for a free queue slot, as a last beat needs one.
  assign in_ready = job_ready;
  assign fire     = in_valid && in_ready;

  assign a_s = $signed(a_element[ElemWidth-1:0]);
  assign b_s = $signed(b_element[ElemWidth-1:0]);
  assign ab  = a_s * b_s;
  assign aa  = a_s * a_s;
  assign bb  = b_s * b_s;
  assign room = ({21'd0, element_count} < MaxLen);

  // Sums after this beat.
  always_comb begin
    dot_next = dot_sum;
    asq_next = a_square_sum;
    bsq_next = b_square_sum;
    cnt_next = element_count;
    ovf_next = overflow_seen;
    if (room) begin
      dot_next = dot_sum + DotW'(ab);
      asq_next = a_square_sum + SqW'(unsigned'(aa));
      bsq_next = b_square_sum + SqW'(unsigned'(bb));
      cnt_next = element_count + 1'b1;
    end else begin
      ovf_next = 1'b1;
    end
  end

  assign job_valid    = fire && last_element;
  assign job.dot      = dot_next;
  assign job.asq      = asq_next;
  assign job.bsq      = bsq_next;
  assign job.too_long = ovf_next;
  assign job.count    = cnt_next;

  // Accumulators clear on reset and after the last beat.
  always_ff @(posedge clk) begin
    if (rst || (fire && last_element)) begin
      dot_sum       <= '0;
      a_square_sum  <= '0;
      b_square_sum  <= '0;
      element_count <= '0;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      dot_sum       <= dot_next;
      a_square_sum  <= asq_next;
      b_square_sum  <= bsq_next;
      element_count <= cnt_next;
      overflow_seen <= ovf_next;
    end
  end
endmodule
`default_nettype wire

// ----- design/cse_queue.sv -----
// ============================================================================
// cse_queue: short job queue
// A four-entry register queue between the front and back ends.
// ============================================================================
`default_nettype none
module cse_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            wr_valid,
  output logic           wr_ready,
  input  cse_pkg::job_t  wr_job,
  output logic           rd_valid,
  input  wire            rd_ready,
  output cse_pkg::job_t  rd_job
);
  import cse_pkg::*;

  job_t            slots [QDepth];
  logic [QPtrW-1:0] wptr, rptr;
  logic [QPtrW:0]   fill;
  logic             push, pop;

  assign wr_ready = (fill != QDepth[QPtrW:0]);
  assign rd_valid = (fill != '0);
  assign rd_job   = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      fill <= fill + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_job;
  end
endmodule
`default_nettype wire

// ----- design/cse_back.sv -----
// ============================================================================
// cse_back: norm and quotient back end
// Forms dot^2*2^30 and a_sq*b_sq with a shared 32x32 multiplier over many
// cycles, then finds the result magnitude one bit a pass, msb first, forming
// norms*m^2 on the same multiplier one word at a time.
// ============================================================================
`default_nettype none
module cse_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              job_valid,
  output logic             job_ready,
  input  cse_pkg::job_t    job,
  output logic             res_valid,
  input  wire              res_ready,
  output cse_pkg::result_t res
);
  import cse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0] state;
  logic       neg, zero, tl;
  logic [CountW-1:0] cnt;

  // Multi-word multiply: x (2 words) * y (2 words), one partial a cycle.
  logic [63:0]  mx, my;
  logic [127:0] acc;
  logic [1:0]   pidx;
  logic         phase;        // 0: dot^2, 1: a_sq*b_sq
  logic [TgtW-1:0]  target;
  logic [NormW-1:0] norms;

  // Search: m built msb first, test = norms * m^2 over three norm words.
  logic [16:0]  m, trial;
  logic [4:0]   bitn;
  logic [2:0]   sub;          // 0: m^2, 1..3: norm words, 4: compare
  logic [31:0]  msq;
  logic [127:0] prod;
  logic         fits;

  logic [31:0] pa, pb, nw;
  logic [63:0] pp;
  logic [31:0] xw0, xw1, yw0, yw1;

  assign xw0 = mx[31:0];
  assign xw1 = mx[63:32];
  assign yw0 = my[31:0];
  assign yw1 = my[63:32];

  // Norm word for the current search step.
  always_comb begin
    case (sub)
      3'd1:    nw = norms[31:0];
      3'd2:    nw = norms[63:32];
      default: nw = 32'(norms[NormW-1:64]);
    endcase
  end

  assign pa   = (state == S_SRCH) ? nw  : (pidx[1] ? xw1 : xw0);
  assign pb   = (state == S_SRCH) ? msq : (pidx[0] ? yw1 : yw0);
  assign pp   = pa * pb;
  assign fits = (prod[TestW-1:0] <= TestW'(target));

  assign job_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            neg   <= job.dot[DotW-1];
            mx    <= 64'(job.dot[DotW-1] ? MagW'(-job.dot) : MagW'(job.dot));
            my    <= 64'(job.dot[DotW-1] ? MagW'(-job.dot) : MagW'(job.dot));
            tl    <= job.too_long;
            cnt   <= job.count;
            zero  <= (job.asq == '0) || (job.bsq == '0);
            norms <= NormW'({job.asq, job.bsq});  // held operands for now
            acc   <= '0;
            pidx  <= '0;
            phase <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // Accumulate one shifted partial product.
          acc  <= acc + (128'(pp) << {2'(pidx[1]) + 2'(pidx[0]), 5'd0});
          pidx <= pidx + 2'd1;
          if (pidx == 2'd3) begin
            if (!phase) begin
              target <= TgtW'((acc + (128'(pp) << 64)) << 30);
              mx     <= 64'(norms[NormW-1:SqW]);
              my     <= 64'(norms[SqW-1:0]);
              acc    <= '0;
              phase  <= 1'b1;
            end else begin
              norms <= NormW'(acc + (128'(pp) << 64));
              m     <= '0;
              bitn  <= 5'd14;
              sub   <= '0;
              state <= zero ? S_OUT : S_SRCH;
              // Full scale is tried first; it is the largest possible magnitude.
              trial <= 17'h08000;
            end
          end
        end
        S_SRCH: begin
          unique case (sub) inside
            3'd0: begin
              msq  <= 32'(trial) * 32'(trial);
              prod <= '0;
              sub  <= 3'd1;
            end
            [3'd1:3'd3]: begin
              prod <= prod + (128'(pp) << {sub - 3'd1, 5'd0});
              sub  <= sub + 3'd1;
            end
            default: begin
              if (fits) m <= trial;
              if (bitn == 5'd31 || (fits && trial[15])) begin
                state <= S_OUT;
              end else begin
                trial <= (fits ? trial : m) | (17'd1 << bitn[3:0]);
                bitn  <= bitn - 5'd1;
              end
              sub <= 3'd0;
            end
          endcase
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result formatting.
  always_comb begin
    res.zero_norm  = zero;
    res.too_long   = tl;
    res.pair_count = cnt;
    if (zero)
      res.similarity = '0;
    else if (neg)
      res.similarity = 16'(-m);
    else
      res.similarity = (m > 17'd32767) ? 16'sd32767 : $signed(m[15:0]);
  end
endmodule
`default_nettype wire

// ----- design/cse_checker.sv -----
// ============================================================================
// cse_checker: port-level checks for the cosine similarity engine
// ============================================================================
`default_nettype none
module cse_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire [1:0]  m_tuser
);
  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");
  // A zero norm forces a zero similarity.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'd0)
    else $error("zero norm with nonzero similarity");
  // The pair count never passes the maximum length.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[26:16] <= 11'd1024)
    else $error("pair count out of range");
  // Overflow implies a full count.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[26:16] == 11'd1024)
    else $error("overflow without full count");
endmodule

bind cosine_similarity_engine cse_checker u_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire

// ----- sim/tb_cosine_similarity_engine.sv -----
// ============================================================================
// tb_cosine_similarity_engine: self-checking bench for the cosine engine.
// Streams element pairs into the block, predicts each vector pair's result
// with an exact integer search, and compares every output beat in order.
// ============================================================================
`default_nettype none
module tb_cosine_similarity_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import cse_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  cosine_similarity_engine i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // Predictor state: exact running sums of the current vector pair.
  logic signed [DotW-1:0] acc_dot;
  logic [SqW-1:0]         acc_asq;
  logic [SqW-1:0]         acc_bsq;
  logic [CountW-1:0]      acc_count;
  logic                   acc_over;

  result_t expected_results[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off = 0;
  int     mismatches = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 2_000_000;

  // Cosine of the finished pair, truncated towards zero by a bit search.
  function automatic result_t cosine_of(logic signed [DotW-1:0] dot,
                                        logic [SqW-1:0] asq, logic [SqW-1:0] bsq);
    result_t r;
    logic [MagW-1:0]   mag;
    logic [TgtW-1:0]   tgt;
    logic [NormW-1:0]  norms;
    logic [TestW-1:0]  trial;
    logic [16:0]       m;
    logic [16:0]       cand;
    r = '0;
    if (asq == 0 || bsq == 0) begin
      r.zero_norm = 1'b1;
      return r;
    end
    mag = dot < 0 ? MagW'(-dot) : MagW'(dot);
    tgt = (TgtW'(mag) * TgtW'(mag)) << 30;
    norms = NormW'(asq) * NormW'(bsq);
    m = '0;
    for (int bit_i = 16; bit_i >= 0; bit_i--) begin
      cand = m | (17'd1 << bit_i);
      if (cand <= 17'd32768) begin
        trial = TestW'(norms) * TestW'(cand) * TestW'(cand);
        if (trial <= TestW'(tgt)) m = cand;
      end
    end
    if (dot < 0) r.similarity = 16'(-m);
    else r.similarity = (m > 17'd32767) ? 16'sd32767 : 16'(m);
    return r;
  endfunction

  // Fold one accepted pair into the predictor.
  task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    result_t r;
    logic signed [31:0] pab, paa, pbb;
    pab = a * b;
    paa = a * a;
    pbb = b * b;
    if (acc_count >= CountW'(MaxLen)) acc_over = 1'b1;
    else begin
      acc_dot = acc_dot + DotW'(pab);
      acc_asq = acc_asq + SqW'(paa);
      acc_bsq = acc_bsq + SqW'(pbb);
      acc_count++;
    end
    if (last) begin
      r = cosine_of(acc_dot, acc_asq, acc_bsq);
      r.too_long = acc_over;
      r.pair_count = acc_count;
      expected_results.push_back(r);
      acc_dot = '0; acc_asq = '0; acc_bsq = '0; acc_count = '0; acc_over = 1'b0;
    end
  endtask

  // Offer one beat, holding it until the block takes it.
  task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pair(a, b, last);
  endtask

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: compare each beat with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h %h", m_tdata, m_tuser);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[15:0] !== want.similarity || m_tuser[0] !== want.zero_norm ||
            m_tuser[1] !== want.too_long || m_tdata[26:16] !== want.pair_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sim %0d zn %b tl %b n %0d, got sim %0d zn %b tl %b n %0d",
                     want.similarity, want.zero_norm, want.too_long, want.pair_count,
                     $signed(m_tdata[15:0]), m_tuser[0], m_tuser[1], m_tdata[26:16]);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("cosine_similarity_engine verification failed");
      $finish;
    end
  end

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);  // identical, saturates at +1
    send_pair(16'h8000, 16'h8000, 1'b1);  // plus one from two minus ones
    send_pair(16'h8000, 16'h7FFF, 1'b1);  // opposite
    send_pair(16'h0000, 16'h1234, 1'b1);  // zero norm on a
    send_pair(16'h1234, 16'h0000, 1'b1);  // zero norm on b
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h4000, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h4000, 1'b1);  // orthogonal
    send_pair(16'h1000, 16'hF000, 1'b0);
    send_pair(16'h3000, 16'h2000, 1'b0);
    send_pair(16'hFFFF, 16'h0001, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    drain();
  endtask

  // Vector longer than the maximum length sets the overflow flag.
  task automatic test_too_long();
    for (int k = 0; k < MaxLen + 3; k++)
      send_pair(rand_elem(), rand_elem(), k == MaxLen + 2);
    drain();
  endtask

  task automatic test_random(int pairs);
    int left;
    left = 0;
    for (int k = 0; k < pairs; k++) begin
      if (left == 0) left = ($urandom_range(9) == 0) ? $urandom_range(40, 1)
                                                      : $urandom_range(6, 1);
      left--;
      send_pair(rand_elem(), rand_elem(), left == 0);
    end
    if (left != 0) send_pair(rand_elem(), rand_elem(), 1'b1);
    drain();
  endtask

  // Long receiver hold-off while short vectors keep coming.
  task automatic test_backpressure();
    hold_off = 1500;
    for (int k = 0; k < 40; k++) send_pair(rand_elem(), rand_elem(), 1'b1);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    acc_dot = '0; acc_asq = '0; acc_bsq = '0; acc_count = '0; acc_over = 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(170);
    send_idle_pct = 67; recv_stall_pct = 0;  test_random(170);
    send_idle_pct = 0;  recv_stall_pct = 67; test_random(170);
    send_idle_pct = 33; recv_stall_pct = 33; test_random(170);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_too_long();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("cosine_similarity_engine verification clean");
    else
      $display("cosine_similarity_engine verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/cse_pkg.sv
design/cse_front.sv
design/cse_queue.sv
design/cse_back.sv
design/cosine_similarity_engine.sv
design/cse_checker.sv
sim/tb_cosine_similarity_engine.sv
